>>> src/etpp_pkg.sv
package etpp_pkg;

  localparam int MAX_STREAMS_DEF = 64;

  localparam logic [31:0] ID_PTR  = 32'h2a707472;
  localparam logic [31:0] ID_DETI = 32'h64657469;
  localparam logic [23:0] ID_EST  = 24'h657374;
  localparam logic [31:0] ID_DMY  = 32'h2a646d79;
  localparam logic [31:0] ID_PTT  = 32'h46707474;
  localparam logic [31:0] ID_SID  = 32'h46736964;
  localparam logic [31:0] ID_SST  = 32'h46737374;
  localparam logic [31:0] ID_AVTM = 32'h61676d74;
  localparam logic [31:0] DETI_SIG = 32'h44455449;
  localparam logic [23:0] TSTA_NONE = 24'hFFFFFF;
  localparam logic [15:0] RFU_NONE = 16'hFFFF;
  localparam logic [15:0] MNSC_NONE = 16'hFFFF;
  localparam logic [8:0] DFLC_MUL = 9'd250;
  localparam logic [9:0] SAD_MASK = 10'h3FF;
  localparam logic [6:0] COUNT_MAX = 7'd127;

  localparam logic [4:0] CODE_ETI    = 5'd0;
  localparam logic [4:0] CODE_ATSTF  = 5'd1;
  localparam logic [4:0] CODE_FICF   = 5'd2;
  localparam logic [4:0] CODE_DFLC   = 5'd3;
  localparam logic [4:0] CODE_ERR    = 5'd4;
  localparam logic [4:0] CODE_MID    = 5'd5;
  localparam logic [4:0] CODE_FP     = 5'd6;
  localparam logic [4:0] CODE_MNSC   = 5'd7;
  localparam logic [4:0] CODE_TVALID = 5'd8;
  localparam logic [4:0] CODE_UTCO   = 5'd9;
  localparam logic [4:0] CODE_SECS   = 5'd10;
  localparam logic [4:0] CODE_TSTA   = 5'd11;
  localparam logic [4:0] CODE_RFU    = 5'd12;
  localparam logic [4:0] CODE_SCID   = 5'd13;
  localparam logic [4:0] CODE_SAD    = 5'd14;
  localparam logic [4:0] CODE_TPL    = 5'd15;
  localparam logic [4:0] CODE_PSIZE  = 5'd16;
  localparam logic [4:0] CODE_FIC    = 5'd17;
  localparam logic [4:0] CODE_SBYTE  = 5'd18;
  localparam logic [4:0] CODE_COUNT  = 5'd19;
  localparam logic [4:0] CODE_STATUS = 5'd20;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_LEN   = 3'd1;
  localparam logic [2:0] ST_UNKNOWN   = 3'd2;
  localparam logic [2:0] ST_PTR_LEN   = 3'd3;
  localparam logic [2:0] ST_DETI_LEN  = 3'd4;
  localparam logic [2:0] ST_BAD_SNUM  = 3'd5;
  localparam logic [2:0] ST_SHORT_EST = 3'd6;
  localparam logic [2:0] ST_TRUNC     = 3'd7;

  // emission order slots; fic byte goes ahead of rfu
  localparam int NPOS       = 21;
  localparam int POS_ETI    = 0;
  localparam int POS_ATSTF  = 1;
  localparam int POS_MNSC   = 7;
  localparam int POS_TVALID = 8;
  localparam int POS_TSTA   = 11;
  localparam int POS_FIC    = 12;
  localparam int POS_RFU    = 13;
  localparam int POS_SCID   = 14;
  localparam int POS_PSIZE  = 17;
  localparam int POS_SBYTE  = 18;
  localparam int POS_COUNT  = 19;
  localparam int POS_STATUS = 20;

  typedef enum logic [2:0] {
    K_UNKNOWN, K_PTR, K_DETI, K_EST, K_SKIP
  } kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_end;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  item_code;
    logic [31:0] item_value;
    logic [5:0]  stream_number;
    logic        run_last;
  } out_item_t;

  typedef struct packed {
    logic [NPOS-1:0] mask;
    logic [47:0]     fh;
    logic [63:0]     ts;
    logic            ts_ok;
    logic [23:0]     rw;
    logic            eti;
    logic [7:0]      data;
    logic [28:0]     psize;
    logic [5:0]      stream;
    logic [6:0]      count;
    logic [2:0]      status;
  } job_t;

  function automatic kind_t kind_of(input logic [31:0] id);
    kind_t k;
    k = K_UNKNOWN;
    if (id == ID_PTR) k = K_PTR;
    else if (id == ID_DETI) k = K_DETI;
    else if (id[31:8] == ID_EST) k = K_EST;
    else if (id == ID_DMY || id == ID_PTT || id == ID_SID || id == ID_SST ||
             id == ID_AVTM) k = K_SKIP;
    return k;
  endfunction

  function automatic logic [4:0] code_of(input logic [4:0] pos);
    logic [4:0] c;
    if (pos < 5'(POS_FIC)) c = pos;
    else if (pos == 5'(POS_FIC)) c = CODE_FIC;
    else if (pos == 5'(POS_RFU)) c = CODE_RFU;
    else if (pos <= 5'(POS_PSIZE)) c = pos - 5'd1;
    else c = pos;
    return c;
  endfunction

endpackage

>>> src/edi_tag_packet_parser_unit.sv
// channel   direction  request            accepted when
// item      in         data_byte, end     push && !full
// result    out        code, value, strm  pop && !empty
//
// one input byte per cycle is taken while the job queue has room
// a byte causing n results hands them out in order, one per accepted pop
// (up to 14 for a deti frame header byte that also closes the packet)
// the 2-entry job queue and the result stage let either side stall alone
// synchronous reset; parser returns to the tag header phase, no results waiting
module edi_tag_packet_parser_unit #(
  parameter int MAX_STREAMS = etpp_pkg::MAX_STREAMS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  etpp_pkg::in_item_t  item,
  input  logic                pop,
  output logic                empty,
  output etpp_pkg::out_item_t result
);

  logic           take, job_valid, q_rd, q_nonempty;
  etpp_pkg::job_t job, q_job;

  assign take = push && !full;

  etpp_front #(.MAX_STREAMS(MAX_STREAMS)) u_front (
    .clk(clk), .rst(rst), .item(item), .take(take),
    .job_valid(job_valid), .job(job)
  );

  etpp_queue u_queue (
    .clk(clk), .rst(rst), .wr(take && job_valid), .wdata(job), .full(full),
    .rd(q_rd), .rdata(q_job), .nonempty(q_nonempty)
  );

  etpp_back u_back (
    .clk(clk), .rst(rst), .q_nonempty(q_nonempty), .q_job(q_job), .q_rd(q_rd),
    .pop(pop), .empty(empty), .result(result)
  );

endmodule

>>> src/etpp_front.sv
module etpp_front #(
  parameter int MAX_STREAMS = etpp_pkg::MAX_STREAMS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  etpp_pkg::in_item_t item,
  input  logic               take,
  output logic               job_valid,
  output etpp_pkg::job_t     job
);

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_VALUE  = 3'b010,
    PH_STOP   = 3'b100
  } phase_t;

  localparam int NPOS_W = etpp_pkg::NPOS;

  phase_t      phase, phase_next;
  logic [2:0]  hcnt, hcnt_next;
  logic [31:0] tid, tid_next;
  logic [28:0] vleft, vleft_next;
  logic [28:0] vidx, vidx_next;
  logic [47:0] fh, fh_next;
  logic [63:0] ts, ts_next;
  logic [23:0] rw, rw_next;
  logic [5:0]  cs, cs_next;
  logic [6:0]  cnt, cnt_next;
  logic [2:0]  stat, stat_next;

  always_comb begin
    logic [7:0] b;
    logic [28:0] len, total;
    logic zero, ts_ok, eti, dh_halt;
    logic [NPOS_W-1:0] mask;
    etpp_pkg::kind_t k;
    logic [7:0] n, tsend, ficn, rfun;
    logic [2:0] status;
    b = item.data_byte;
    phase_next = phase; hcnt_next = hcnt; tid_next = tid; vleft_next = vleft;
    vidx_next = vidx; fh_next = fh; ts_next = ts; rw_next = rw; cs_next = cs;
    cnt_next = cnt; stat_next = stat;
    mask = '0; ts_ok = 1'b0; eti = 1'b0; dh_halt = 1'b0;
    len = '0; zero = 1'b0; n = tid[7:0];
    k = etpp_pkg::kind_of(tid);
    total = vidx + vleft;
    tsend = '0; ficn = '0; rfun = '0; status = '0;
    case (phase)
      PH_HEADER: begin
        if (hcnt < 3'd4) tid_next = {tid[23:0], b};
        else if (hcnt == 3'd4) vleft_next = 29'(b);
        else if (hcnt < 3'd7) vleft_next = {vleft[20:0], b};
        hcnt_next = hcnt + 3'd1;
        if (hcnt == 3'd7) begin
          len = {vleft[23:0], b[7:3]};
          zero = (vleft == '0) && (b == 8'd0);
          hcnt_next = '0;
          if (item.packet_end) begin
            vleft_next = '0;
            if (!zero) begin
              phase_next = PH_STOP; stat_next = etpp_pkg::ST_TRUNC;
            end
          end else if (b[2:0] != 3'd0) begin
            phase_next = PH_STOP; stat_next = etpp_pkg::ST_BAD_LEN;
          end else begin
            vidx_next = '0;
            vleft_next = len;
            phase_next = PH_VALUE;
            if (k == etpp_pkg::K_UNKNOWN) begin
              phase_next = PH_STOP; stat_next = etpp_pkg::ST_UNKNOWN;
            end else if (k == etpp_pkg::K_PTR && len != 29'd8) begin
              phase_next = PH_STOP; stat_next = etpp_pkg::ST_PTR_LEN;
            end else if (k == etpp_pkg::K_DETI && len < 29'd6) begin
              phase_next = PH_STOP; stat_next = etpp_pkg::ST_DETI_LEN;
            end else if (k == etpp_pkg::K_EST &&
                         (n == 8'd0 || 32'(n) > 32'(MAX_STREAMS))) begin
              phase_next = PH_STOP; stat_next = etpp_pkg::ST_BAD_SNUM;
            end else if (k == etpp_pkg::K_EST && len < 29'd3) begin
              phase_next = PH_STOP; stat_next = etpp_pkg::ST_SHORT_EST;
            end else begin
              if (k == etpp_pkg::K_EST) cs_next = 6'(n - 8'd1);
              if (len == '0) phase_next = PH_HEADER;
            end
          end
        end
      end
      PH_VALUE: begin
        if (k == etpp_pkg::K_PTR) begin
          ts_next = {ts[55:0], b};
          eti = (ts_next == {etpp_pkg::DETI_SIG, 32'd0});
          if (vidx == 29'd7) mask[etpp_pkg::POS_ETI] = 1'b1;
        end else if (k == etpp_pkg::K_DETI) begin
          if (vidx < 29'd6) fh_next = {fh[39:0], b};
          tsend = fh_next[47] ? 8'd14 : 8'd6;
          ficn = fh_next[46] ? ((fh_next[23:22] == 2'd3) ? 8'd128 : 8'd96) : 8'd0;
          rfun = fh_next[45] ? 8'd3 : 8'd0;
          if (vidx == 29'd5) begin
            if (total != 29'(tsend) + 29'(ficn) + 29'(rfun)) begin
              dh_halt = 1'b1;
              phase_next = PH_STOP; stat_next = etpp_pkg::ST_DETI_LEN;
            end else begin
              mask[etpp_pkg::POS_MNSC:etpp_pkg::POS_ATSTF] = '1;
              if (!fh_next[47]) mask[etpp_pkg::POS_TSTA:etpp_pkg::POS_TVALID] = '1;
            end
          end else if (vidx >= 29'd6) begin
            if (vidx < 29'(tsend)) begin
              ts_next = {ts[55:0], b};
              if (vidx == 29'd13) begin
                mask[etpp_pkg::POS_TSTA:etpp_pkg::POS_TVALID] = '1;
                ts_ok = 1'b1;
              end
            end else if (vidx < 29'(tsend) + 29'(ficn)) begin
              mask[etpp_pkg::POS_FIC] = 1'b1;
            end else begin
              rw_next = {rw[15:0], b};
            end
          end
          if (!dh_halt && (vidx + 29'd1 == total)) mask[etpp_pkg::POS_RFU] = 1'b1;
        end else if (k == etpp_pkg::K_EST) begin
          if (vidx < 29'd3) begin
            rw_next = {rw[15:0], b};
            if (vidx == 29'd2) mask[etpp_pkg::POS_PSIZE:etpp_pkg::POS_SCID] = '1;
          end else begin
            mask[etpp_pkg::POS_SBYTE] = 1'b1;
          end
          if (vleft == 29'd1 && cnt < etpp_pkg::COUNT_MAX) cnt_next = cnt + 7'd1;
        end
        if (phase_next == PH_VALUE) begin
          vidx_next = vidx + 29'd1;
          vleft_next = vleft - 29'd1;
          if (vleft == 29'd1) begin
            phase_next = PH_HEADER;
            hcnt_next = '0;
          end
        end
      end
      PH_STOP: begin
      end
      default: phase_next = PH_STOP;
    endcase

    status = stat_next;
    if (phase_next == PH_VALUE || (phase_next == PH_HEADER && hcnt_next != 3'd0))
      status = etpp_pkg::ST_TRUNC;
    job.count = cnt_next;
    job.status = status;
    if (item.packet_end) begin
      mask[etpp_pkg::POS_COUNT] = 1'b1;
      mask[etpp_pkg::POS_STATUS] = 1'b1;
      phase_next = PH_HEADER;
      hcnt_next = '0;
      vleft_next = '0;
      vidx_next = '0;
      cnt_next = '0;
      stat_next = etpp_pkg::ST_OK;
    end
    job.mask = mask;
    job.fh = fh_next;
    job.ts = ts_next;
    job.ts_ok = ts_ok;
    job.rw = rw_next;
    job.eti = eti;
    job.data = b;
    job.psize = total - 29'd3;
    job.stream = cs;
    job_valid = (mask != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
      hcnt <= '0;
      tid <= '0;
      vleft <= '0;
      vidx <= '0;
      fh <= '0;
      ts <= '0;
      rw <= '1;
      cs <= '0;
      cnt <= '0;
      stat <= '0;
    end else if (take) begin
      phase <= phase_next;
      hcnt <= hcnt_next;
      tid <= tid_next;
      vleft <= vleft_next;
      vidx <= vidx_next;
      fh <= fh_next;
      ts <= ts_next;
      rw <= rw_next;
      cs <= cs_next;
      cnt <= cnt_next;
      stat <= stat_next;
    end
  end

endmodule

>>> src/etpp_queue.sv
module etpp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  etpp_pkg::job_t wdata,
  output logic           full,
  input  logic           rd,
  output etpp_pkg::job_t rdata,
  output logic           nonempty
);

  etpp_pkg::job_t slot [2];
  logic       wptr, rptr;
  logic [1:0] count;

  assign full = (count == 2'd2);
  assign nonempty = (count != 2'd0);
  assign rdata = slot[rptr];

  always_ff @(posedge clk) begin
    if (wr) slot[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= '0;
    end else begin
      if (wr) wptr <= ~wptr;
      if (rd) rptr <= ~rptr;
      count <= count + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

>>> src/etpp_back.sv
module etpp_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_nonempty,
  input  etpp_pkg::job_t      q_job,
  output logic                q_rd,
  input  logic                pop,
  output logic                empty,
  output etpp_pkg::out_item_t result
);

  logic                      valid;
  etpp_pkg::job_t            cur;
  logic [etpp_pkg::NPOS-1:0] mask;
  logic [etpp_pkg::NPOS-1:0] sel;
  logic [4:0]                pos;
  logic                      last;

  // lowest pending slot goes first
  always_comb begin
    sel = '0;
    pos = '0;
    for (int i = etpp_pkg::NPOS - 1; i >= 0; i--) begin
      if (mask[i]) begin
        sel = '0;
        sel[i] = 1'b1;
        pos = 5'(i);
      end
    end
  end

  assign last = ((mask & ~sel) == '0);
  assign empty = !valid;
  assign q_rd = q_nonempty && (!valid || (pop && last));

  always_comb begin
    logic [4:0] code;
    logic [31:0] v;
    code = etpp_pkg::code_of(pos);
    v = '0;
    case (code)
      etpp_pkg::CODE_ETI:    v = 32'(cur.eti);
      etpp_pkg::CODE_ATSTF:  v = 32'(cur.fh[47]);
      etpp_pkg::CODE_FICF:   v = 32'(cur.fh[46]);
      etpp_pkg::CODE_DFLC:   v = 32'(cur.fh[44:40]) * 32'(etpp_pkg::DFLC_MUL)
                                 + 32'(cur.fh[39:32]);
      etpp_pkg::CODE_ERR:    v = 32'(cur.fh[31:24]);
      etpp_pkg::CODE_MID:    v = 32'(cur.fh[23:22]);
      etpp_pkg::CODE_FP:     v = 32'(cur.fh[21:19]);
      etpp_pkg::CODE_MNSC:   v = cur.fh[16] ? 32'(etpp_pkg::MNSC_NONE) : 32'(cur.fh[15:0]);
      etpp_pkg::CODE_TVALID: v = 32'(cur.ts_ok);
      etpp_pkg::CODE_UTCO:   v = cur.ts_ok ? 32'(cur.ts[63:56]) : 32'd0;
      etpp_pkg::CODE_SECS:   v = cur.ts_ok ? cur.ts[55:24] : 32'd0;
      etpp_pkg::CODE_TSTA:   v = cur.ts_ok ? 32'(cur.ts[23:0]) : 32'(etpp_pkg::TSTA_NONE);
      etpp_pkg::CODE_RFU:    v = cur.fh[45] ? 32'(cur.rw[23:8]) : 32'(etpp_pkg::RFU_NONE);
      etpp_pkg::CODE_SCID:   v = 32'(cur.rw[23:18]);
      etpp_pkg::CODE_SAD:    v = 32'(cur.rw[17:8] & etpp_pkg::SAD_MASK);
      etpp_pkg::CODE_TPL:    v = 32'(cur.rw[7:2]);
      etpp_pkg::CODE_PSIZE:  v = 32'(cur.psize);
      etpp_pkg::CODE_FIC:    v = 32'(cur.data);
      etpp_pkg::CODE_SBYTE:  v = 32'(cur.data);
      etpp_pkg::CODE_COUNT:  v = 32'(cur.count);
      etpp_pkg::CODE_STATUS: v = 32'(cur.status);
      default:               v = '0;
    endcase
    result.item_code = code;
    result.item_value = v;
    result.stream_number = (code >= etpp_pkg::CODE_SCID && code <= etpp_pkg::CODE_SBYTE)
                           ? cur.stream : 6'd0;
    result.run_last = last;
  end

  always_ff @(posedge clk) begin
    if (q_rd) cur <= q_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      mask <= '0;
    end else if (q_rd) begin
      valid <= 1'b1;
      mask <= q_job.mask;
    end else if (valid && pop) begin
      mask <= mask & ~sel;
      if (last) valid <= 1'b0;
    end
  end

endmodule

>>> src/etpp_checker.sv
module etpp_checker (
  input logic                clk,
  input logic                rst,
  input logic                full,
  input logic                pop,
  input logic                empty,
  input etpp_pkg::out_item_t result
);

  a_reset_clear: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("results or full after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(result))
    else $error("waiting result changed");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    !empty && result.item_code == etpp_pkg::CODE_STATUS |-> result.run_last)
    else $error("status not last of its byte");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> result.item_code <= etpp_pkg::CODE_STATUS)
    else $error("bad item code");

  a_stream_zero: assert property (@(posedge clk) disable iff (rst)
    !empty && (result.item_code < etpp_pkg::CODE_SCID ||
               result.item_code > etpp_pkg::CODE_SBYTE) |-> result.stream_number == 6'd0)
    else $error("stream number on non-stream item");

endmodule

bind edi_tag_packet_parser_unit etpp_checker u_checker (
  .clk(clk), .rst(rst), .full(full),
  .pop(pop), .empty(empty), .result(result)
);

>>> dv/etpp_checker.sv
module etpp_scoreboard (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic                full,
  input  etpp_pkg::in_item_t  item,
  input  logic                pop,
  input  logic                empty,
  input  etpp_pkg::out_item_t result,
  output int                  errors,
  output int                  open_count
);

  localparam logic [1:0] PH_HDR  = 2'd0;
  localparam logic [1:0] PH_VAL  = 2'd1;
  localparam logic [1:0] PH_STOP = 2'd2;
  localparam int MAX_PER_BYTE = 14;

  logic [1:0]  ph;
  logic [2:0]  hdr_cnt;
  logic [31:0] tag_id;
  logic [28:0] left;
  logic [28:0] idx;
  logic [47:0] fh;
  logic [63:0] ts;
  logic [23:0] rw;
  logic [5:0]  cur;
  logic [6:0]  cnt;
  logic [2:0]  stop_st;

  etpp_pkg::out_item_t decoded_q[$];
  etpp_pkg::out_item_t byte_q[$];

  function automatic etpp_pkg::kind_t tag_kind(input logic [31:0] id);
    if (id == etpp_pkg::ID_PTR) return etpp_pkg::K_PTR;
    if (id == etpp_pkg::ID_DETI) return etpp_pkg::K_DETI;
    if (id[31:8] == etpp_pkg::ID_EST) return etpp_pkg::K_EST;
    if (id == etpp_pkg::ID_DMY || id == etpp_pkg::ID_PTT || id == etpp_pkg::ID_SID ||
        id == etpp_pkg::ID_SST || id == etpp_pkg::ID_AVTM)
      return etpp_pkg::K_SKIP;
    return etpp_pkg::K_UNKNOWN;
  endfunction

  task automatic clear_state();
    ph = PH_HDR;
    hdr_cnt = '0;
    tag_id = '0;
    left = '0;
    idx = '0;
    fh = '0;
    ts = '0;
    rw = 24'hFFFFFF;
    cur = '0;
    cnt = '0;
    stop_st = etpp_pkg::ST_OK;
    decoded_q.delete();
  endtask

  task automatic add(input logic [4:0] code, input logic [31:0] value, input logic [5:0] strm);
    etpp_pkg::out_item_t o;
    if (byte_q.size() < MAX_PER_BYTE) begin
      o.item_code = code;
      o.item_value = value;
      o.stream_number = strm;
      o.run_last = 1'b0;
      byte_q = {byte_q, o};
    end
  endtask

  task automatic halt_parse(input logic [2:0] st);
    ph = PH_STOP;
    stop_st = st;
  endtask

  task automatic open_tag(input logic [28:0] len);
    etpp_pkg::kind_t k;
    logic [7:0] n;
    k = tag_kind(tag_id);
    n = tag_id[7:0];
    idx = '0;
    left = len;
    ph = PH_VAL;
    if (k == etpp_pkg::K_UNKNOWN) begin
      halt_parse(etpp_pkg::ST_UNKNOWN);
      return;
    end
    if (k == etpp_pkg::K_PTR && len != 29'd8) begin
      halt_parse(etpp_pkg::ST_PTR_LEN);
      return;
    end
    if (k == etpp_pkg::K_DETI && len < 29'd6) begin
      halt_parse(etpp_pkg::ST_DETI_LEN);
      return;
    end
    if (k == etpp_pkg::K_EST) begin
      if (n == 8'd0 || int'(n) > etpp_pkg::MAX_STREAMS_DEF) begin
        halt_parse(etpp_pkg::ST_BAD_SNUM);
        return;
      end
      if (len < 29'd3) begin
        halt_parse(etpp_pkg::ST_SHORT_EST);
        return;
      end
      cur = 6'(n - 8'd1);
    end
    if (len == '0) ph = PH_HDR;
  endtask

  task automatic frame_byte(input logic [7:0] b, input logic [28:0] i, input logic [28:0] total);
    logic [15:0] dh;
    logic [31:0] eh;
    logic [1:0]  mid;
    int fic, tsend, rfu_len;
    if (i < 29'd6) fh = {fh[39:0], b};
    dh = fh[47:32];
    eh = fh[31:0];
    mid = eh[23:22];
    fic = dh[14] ? (mid == 2'd3 ? 128 : 96) : 0;
    tsend = dh[15] ? 14 : 6;
    rfu_len = dh[13] ? 3 : 0;
    if (i == 29'd5) begin
      if (int'(total) != tsend + fic + rfu_len) begin
        halt_parse(etpp_pkg::ST_DETI_LEN);
        return;
      end
      add(etpp_pkg::CODE_ATSTF, 32'(dh[15]), 6'd0);
      add(etpp_pkg::CODE_FICF, 32'(dh[14]), 6'd0);
      add(etpp_pkg::CODE_DFLC, 32'(dh[12:8]) * 32'd250 + 32'(dh[7:0]), 6'd0);
      add(etpp_pkg::CODE_ERR, 32'(eh[31:24]), 6'd0);
      add(etpp_pkg::CODE_MID, 32'(mid), 6'd0);
      add(etpp_pkg::CODE_FP, 32'(eh[21:19]), 6'd0);
      add(etpp_pkg::CODE_MNSC, eh[16] ? 32'hFFFF : 32'(eh[15:0]), 6'd0);
      if (!dh[15]) begin
        add(etpp_pkg::CODE_TVALID, 32'd0, 6'd0);
        add(etpp_pkg::CODE_UTCO, 32'd0, 6'd0);
        add(etpp_pkg::CODE_SECS, 32'd0, 6'd0);
        add(etpp_pkg::CODE_TSTA, 32'hFFFFFF, 6'd0);
      end
    end else if (i >= 29'd6) begin
      if (int'(i) < tsend) begin
        ts = {ts[55:0], b};
        if (i == 29'd13) begin
          add(etpp_pkg::CODE_TVALID, 32'd1, 6'd0);
          add(etpp_pkg::CODE_UTCO, 32'(ts[63:56]), 6'd0);
          add(etpp_pkg::CODE_SECS, ts[55:24], 6'd0);
          add(etpp_pkg::CODE_TSTA, 32'(ts[23:0]), 6'd0);
        end
      end else if (int'(i) < tsend + fic) begin
        add(etpp_pkg::CODE_FIC, 32'(b), 6'd0);
      end else begin
        rw = {rw[15:0], b};
      end
    end
    if (i + 29'd1 == total)
      add(etpp_pkg::CODE_RFU, dh[13] ? 32'(rw[23:8]) : 32'hFFFF, 6'd0);
  endtask

  task automatic value_byte(input logic [7:0] b);
    logic [28:0] i, total;
    logic last;
    etpp_pkg::kind_t k;
    i = idx;
    total = i + left;
    last = (left == 29'd1);
    k = tag_kind(tag_id);
    if (k == etpp_pkg::K_PTR) begin
      ts = {ts[55:0], b};
      if (i == 29'd7)
        add(etpp_pkg::CODE_ETI, (ts == {etpp_pkg::DETI_SIG, 32'h0}) ? 32'd1 : 32'd0, 6'd0);
    end else if (k == etpp_pkg::K_DETI) begin
      frame_byte(b, i, total);
    end else if (k == etpp_pkg::K_EST) begin
      if (i < 29'd3) begin
        rw = {rw[15:0], b};
        if (i == 29'd2) begin
          add(etpp_pkg::CODE_SCID, 32'(rw[23:18]), cur);
          add(etpp_pkg::CODE_SAD, 32'(rw[17:8]), cur);
          add(etpp_pkg::CODE_TPL, 32'(rw[7:2]), cur);
          add(etpp_pkg::CODE_PSIZE, 32'(total) - 32'd3, cur);
        end
      end else begin
        add(etpp_pkg::CODE_SBYTE, 32'(b), cur);
      end
      if (last && cnt < 7'd127) cnt = cnt + 7'd1;
    end
    if (ph == PH_VAL) begin
      idx = i + 29'd1;
      left = left - 29'd1;
      if (left == '0) begin
        ph = PH_HDR;
        hdr_cnt = '0;
      end
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic e);
    logic [2:0]  k;
    logic [28:0] len;
    logic        zero;
    logic [2:0]  st;
    byte_q.delete();
    if (ph == PH_HDR) begin
      k = hdr_cnt;
      if (k < 3'd4) tag_id = {tag_id[23:0], b};
      else if (k == 3'd4) left = {21'd0, b};
      else if (k < 3'd7) left = {left[20:0], b};
      hdr_cnt = k + 3'd1;
      if (k == 3'd7) begin
        len = {left[23:0], b[7:3]};
        zero = (left == '0 && b == 8'd0);
        hdr_cnt = '0;
        if (e) begin
          left = '0;
          if (!zero) halt_parse(etpp_pkg::ST_TRUNC);
        end else if (b[2:0] != 3'd0) begin
          halt_parse(etpp_pkg::ST_BAD_LEN);
        end else begin
          open_tag(len);
        end
      end
    end else if (ph == PH_VAL) begin
      value_byte(b);
    end else if (ph != PH_STOP) begin
      ph = PH_STOP;
    end
    if (e) begin
      st = stop_st;
      if (ph == PH_VAL || (ph == PH_HDR && hdr_cnt != 3'd0)) st = etpp_pkg::ST_TRUNC;
      add(etpp_pkg::CODE_COUNT, 32'(cnt), 6'd0);
      add(etpp_pkg::CODE_STATUS, 32'(st), 6'd0);
      ph = PH_HDR;
      hdr_cnt = '0;
      left = '0;
      idx = '0;
      cnt = '0;
      stop_st = etpp_pkg::ST_OK;
    end
    if (byte_q.size() > 0) byte_q[byte_q.size() - 1].run_last = 1'b1;
    decoded_q = {decoded_q, byte_q};
  endtask

  task automatic report(input string field, input logic [31:0] want, input logic [31:0] got);
    $display("%0t mismatch %s: expected %0h actual %0h", $time, field, want, got);
    errors++;
  endtask

  initial begin
    errors = 0;
    open_count = 0;
    clear_state();
  end

  always @(posedge clk) begin
    etpp_pkg::out_item_t want;
    if (rst) begin
      clear_state();
    end else begin
      if (push && !full) decode_byte(item.data_byte, item.packet_end);
      if (pop && !empty) begin
        if (decoded_q.size() == 0) begin
          $display("%0t unexpected result: expected none actual %h", $time, result);
          errors++;
        end else begin
          want = decoded_q.pop_front();
          if (want.item_code !== result.item_code)
            report("item_code", 32'(want.item_code), 32'(result.item_code));
          if (want.item_value !== result.item_value)
            report("item_value", want.item_value, result.item_value);
          if (want.stream_number !== result.stream_number)
            report("stream_number", 32'(want.stream_number), 32'(result.stream_number));
          if (want.run_last !== result.run_last)
            report("run_last", 32'(want.run_last), 32'(result.run_last));
        end
      end
    end
    open_count <= decoded_q.size();
  end

endmodule

>>> dv/tb_edi_tag_packet_parser_unit.sv
module tb_edi_tag_packet_parser_unit;

  logic                clk;
  logic                rst;
  logic                push;
  logic                full;
  etpp_pkg::in_item_t  item;
  logic                pop;
  logic                empty;
  etpp_pkg::out_item_t result;
  int                  errors;
  int                  open_count;
  int                  cycle;
  int                  sent;
  bit                  tx_steady;
  logic [7:0]          pkt[$];

  edi_tag_packet_parser_unit uut (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .pop(pop), .empty(empty), .result(result)
  );

  etpp_scoreboard chk (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .pop(pop), .empty(empty), .result(result),
    .errors(errors), .open_count(open_count)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk) cycle <= rst ? 0 : cycle + 1;

  // receiver: long hold-off early on, a steady window later, random stalls elsewhere
  initial begin
    int hold;
    pop = 0;
    hold = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (cycle == 10) hold = 120;
      if (hold > 0) begin
        hold--;
        pop <= 1'b0;
      end else if (cycle > 150 && cycle < 250) begin
        pop <= 1'b1;
      end else begin
        pop <= ($urandom_range(99) >= 38);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic e);
    while (!tx_steady && $urandom_range(99) < 38) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= '{data_byte: b, packet_end: e};
    do @(posedge clk); while (full);
  endtask

  task automatic send_packet();
    if (pkt.size() == 0) pkt = {pkt, 8'($urandom)};
    sent += pkt.size();
    foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
    pkt.delete();
  endtask

  task automatic add_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) pkt = {pkt, w[8*i +: 8]};
  endtask

  task automatic add_head(input logic [31:0] id, input int nbytes, input logic [2:0] low);
    add_word(id);
    add_word({nbytes[28:0], low});
  endtask

  task automatic add_ptr(input bit good, input int nbytes);
    logic [63:0] sig;
    sig = good ? {etpp_pkg::DETI_SIG, 32'h0} : {$urandom, $urandom};
    add_head(etpp_pkg::ID_PTR, nbytes, 3'd0);
    for (int i = 0; i < nbytes; i++) pkt = {pkt, (i < 8 ? sig[63 - 8*i -: 8] : 8'($urandom))};
  endtask

  task automatic add_frame(input bit atstf, input bit ficf, input bit rfudf,
                           input logic [1:0] mid, input int delta);
    logic [47:0] fh;
    int n;
    fh = 48'({$urandom, $urandom});
    fh[47:45] = {atstf, ficf, rfudf};
    fh[23:22] = mid;
    n = 6 + (atstf ? 8 : 0) + (ficf ? (mid == 2'd3 ? 128 : 96) : 0) + (rfudf ? 3 : 0) + delta;
    add_head(etpp_pkg::ID_DETI, n, 3'd0);
    for (int i = 0; i < n; i++) pkt = {pkt, (i < 6 ? fh[47 - 8*i -: 8] : 8'($urandom))};
  endtask

  task automatic add_stream(input logic [7:0] num, input int nbytes);
    add_head({etpp_pkg::ID_EST, num}, nbytes, 3'd0);
    for (int i = 0; i < nbytes; i++) pkt = {pkt, 8'($urandom)};
  endtask

  task automatic add_ignored(input int nbytes);
    logic [31:0] ids[5];
    ids = '{etpp_pkg::ID_DMY, etpp_pkg::ID_PTT, etpp_pkg::ID_SID, etpp_pkg::ID_SST,
            etpp_pkg::ID_AVTM};
    add_head(ids[$urandom_range(4)], nbytes, 3'd0);
    for (int i = 0; i < nbytes; i++) pkt = {pkt, 8'($urandom)};
  endtask

  task automatic add_random_tag();
    int pick;
    pick = $urandom_range(99);
    if (pick < 15) add_ptr($urandom_range(3) != 0, $urandom_range(9) == 0 ? $urandom_range(12) : 8);
    else if (pick < 45)
      add_frame(1'($urandom_range(1)), 1'b0, 1'($urandom_range(1)), 2'($urandom),
                $urandom_range(7) == 0 ? int'($urandom_range(4)) - 2 : 0);
    else if (pick < 80)
      add_stream($urandom_range(9) == 0 ? 8'($urandom) : 8'($urandom_range(1, 64)),
                 $urandom_range(9) == 0 ? $urandom_range(2) : $urandom_range(3, 10));
    else if (pick < 90) add_ignored($urandom_range(5));
    else if (pick < 95) add_head($urandom, $urandom_range(4), 3'd0);
    else add_head(etpp_pkg::ID_PTR, 8, 3'($urandom_range(1, 7)));
  endtask

  initial begin
    rst = 1;
    push = 0;
    item = '0;
    tx_steady = 0;
    sent = 0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed packets, the first one sent without gaps
    tx_steady = 1;
    add_ptr(1, 8); add_stream(8'd64, 3); add_stream(8'd1, 5);
    send_packet();
    tx_steady = 0;
    add_frame(0, 0, 0, 2'd0, 0);          // frame header ends the packet
    send_packet();
    add_frame(1, 0, 1, 2'd2, 0); send_packet();   // timestamp and rfu
    add_frame(0, 1, 0, 2'd1, 0);                  // packet ends among fic bytes
    while (pkt.size() > 18) void'(pkt.pop_back());
    send_packet();
    add_head(32'hFFFFFFFF, 0, 3'd0); send_packet();

    while (sent < 110) begin
      if ($urandom_range(11) == 0) begin
        repeat ($urandom_range(1, 10)) pkt = {pkt, 8'($urandom)};
      end else begin
        repeat ($urandom_range(1, 3)) add_random_tag();
        if ($urandom_range(7) == 0) repeat ($urandom_range(1, pkt.size() - 1)) void'(pkt.pop_back());
      end
      send_packet();
    end
    push <= 1'b0;

    repeat (2) @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
